// ===== src/fasthash64_stream_hasher_top_assert.svh =====
// Assertion macros shared by the checker of the stream hasher.
`ifndef FASTHASH64_STREAM_HASHER_TOP_ASSERT_SVH
`define FASTHASH64_STREAM_HASHER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define FH64_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fh64 assertion failed");

// Next-cycle implication, sampled on the rising clock edge, idle in reset.
`define FH64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fh64 assertion failed");

`endif

// ===== src/fh64_pkg.sv =====
package fh64_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int NBYTES_W = 4;
    localparam int BYTES_PER_WORD = WORD_W / 8;

    localparam logic [WORD_W-1:0] HASH_M = 64'h880355f21e6d1965;
    localparam logic [WORD_W-1:0] MIX_K  = 64'h2127599bf4325c37;
    localparam int SHIFT_A = 23;
    localparam int SHIFT_B = 47;

    // Request into the shared multiplier.
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    // Response from the shared multiplier.
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } mul_rsp_t;

    // First xorshift of the mix.
    function automatic logic [WORD_W-1:0] xs_a(input logic [WORD_W-1:0] v);
        return v ^ (v >> SHIFT_A);
    endfunction

    // Second xorshift of the mix.
    function automatic logic [WORD_W-1:0] xs_b(input logic [WORD_W-1:0] v);
        return v ^ (v >> SHIFT_B);
    endfunction

    // Clear every byte at or above the valid byte count.
    function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
                                                    input logic [NBYTES_W-1:0] n);
        logic [WORD_W-1:0] m;
        m = w;
        for (int i = 0; i < BYTES_PER_WORD; i++) begin
            if (NBYTES_W'(i) >= n) begin
                m[i*8 +: 8] = 8'h00;
            end
        end
        return m;
    endfunction

endpackage

// ===== src/fh64_mul.sv =====
module fh64_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  fh64_pkg::mul_req_t req,
    output fh64_pkg::mul_rsp_t rsp
);
    import fh64_pkg::*;

    typedef enum logic [4:0] {
        MS_IDLE = 5'b00001,
        MS_LL   = 5'b00010,
        MS_LH   = 5'b00100,
        MS_HL   = 5'b01000,
        MS_SUM  = 5'b10000
    } mstep_t;

    mstep_t            step_reg;
    logic              done_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [WORD_W-1:0] prod_next;

    // Pick the operand halves for the current partial product.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            MS_LL:
            begin
                op_a = a_reg[HALF_W-1:0];
                op_b = b_reg[HALF_W-1:0];
            end
            MS_LH:
            begin
                op_a = a_reg[HALF_W-1:0];
                op_b = b_reg[WORD_W-1:HALF_W];
            end
            MS_HL:
            begin
                op_a = a_reg[WORD_W-1:HALF_W];
                op_b = b_reg[HALF_W-1:0];
            end
            MS_IDLE, MS_SUM:
            begin
                op_a = '0;
                op_b = '0;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // The one 32 by 32 multiplier, registered before the accumulate.
    assign prod_next = WORD_W'(op_a) * WORD_W'(op_b);

    // Step sequencer: three partial products, the high ones shifted into the top half.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= MS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (step_reg)
                MS_IDLE:
                begin
                    if (req.start)
                    begin
                        step_reg <= MS_LL;
                    end
                end
                MS_LL:   step_reg <= MS_LH;
                MS_LH:   step_reg <= MS_HL;
                MS_HL:   step_reg <= MS_SUM;
                MS_SUM:
                begin
                    step_reg <= MS_IDLE;
                    done_reg <= 1'b1;
                end
                default: step_reg <= MS_IDLE;
            endcase
        end
    end

    // Operand capture and accumulation.
    always_ff @(posedge clk)
    begin
        if (step_reg == MS_IDLE && req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        prod_reg <= prod_next;
        if (step_reg == MS_LH)
        begin
            acc_reg <= prod_reg;
        end
        else if (step_reg == MS_HL || step_reg == MS_SUM)
        begin
            acc_reg <= acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// ===== src/fasthash64_stream_hasher_top.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_ready  data_word, valid_bytes, first_word,
//                                           last_word, message_length
// out       output     out_valid/out_ready  hash_value
// cfg       input      cfg_valid/cfg_ready  hash_seed
//
// Every 64-bit multiply runs on one shared 32 by 32 multiplier and holds the sequencer
// until it is done. A word with valid bytes takes two multiplies, a first word one more,
// a last word one more plus the S_EMIT step to load the output register. The input is
// not ready while a word is in progress.
// Reset is asynchronous and active low; it clears the seed and the running hash.
// A result waiting on out_ready does not block the next request; only a later
// result waits for the output register to free up.
module fasthash64_stream_hasher_top #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_word,
    input  logic [3:0]  valid_bytes,
    input  logic        first_word,
    input  logic        last_word,
    input  logic [31:0] message_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] hash_seed
);
    import fh64_pkg::*;

    localparam int LEN_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_MIXW = 6'b000100,
        S_MULH = 6'b001000,
        S_FIN  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] hash_reg;
    logic [WORD_W-1:0] hash_next;
    logic              start_reg;
    logic              start_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_hash_reg;
    logic [WORD_W-1:0] out_hash_next;
    logic [WORD_W-1:0] emit_reg;
    logic [WORD_W-1:0] emit_next;
    logic [WORD_W-1:0] word_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              absorb_reg;
    logic              last_reg;
    logic              in_accept;
    logic              absorb_in;
    mul_req_t          mreq;
    mul_rsp_t          mrsp;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign absorb_in = (valid_bytes != '0);

    // Shared multiplier.
    fh64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // Operand selection for the multiply of the current step.
    always_comb
    begin
        mreq.start = start_reg;
        mreq.a     = '0;
        mreq.b     = '0;
        unique case (state_reg)
            S_INIT:
            begin
                mreq.a = WORD_W'(len_reg);
                mreq.b = HASH_M;
            end
            S_MIXW:
            begin
                mreq.a = xs_a(word_reg);
                mreq.b = MIX_K;
            end
            S_MULH:
            begin
                mreq.a = hash_reg;
                mreq.b = HASH_M;
            end
            S_FIN:
            begin
                mreq.a = xs_a(hash_reg);
                mreq.b = MIX_K;
            end
            S_IDLE, S_EMIT:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    // Sequencer: load, absorb, scramble by M, final mix, hand over to the output.
    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        start_next     = 1'b0;
        emit_next      = emit_reg;
        out_hash_next  = out_hash_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (first_word)
                    begin
                        state_next = S_INIT;
                        start_next = 1'b1;
                    end
                    else if (absorb_in)
                    begin
                        state_next = S_MIXW;
                        start_next = 1'b1;
                    end
                    else if (last_word)
                    begin
                        state_next = S_FIN;
                        start_next = 1'b1;
                    end
                end
            end
            S_INIT:
            begin
                if (mrsp.done)
                begin
                    hash_next = seed_reg ^ mrsp.result;
                    if (absorb_reg)
                    begin
                        state_next = S_MIXW;
                        start_next = 1'b1;
                    end
                    else if (last_reg)
                    begin
                        state_next = S_FIN;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MIXW:
            begin
                if (mrsp.done)
                begin
                    hash_next  = hash_reg ^ xs_b(mrsp.result);
                    state_next = S_MULH;
                    start_next = 1'b1;
                end
            end
            S_MULH:
            begin
                if (mrsp.done)
                begin
                    hash_next = mrsp.result;
                    if (last_reg)
                    begin
                        state_next = S_FIN;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (mrsp.done)
                begin
                    emit_next  = xs_b(mrsp.result);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_hash_next  = emit_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, seed and running hash.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
            hash_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            hash_reg      <= hash_next;
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= hash_seed;
            end
        end
    end

    // Captured request fields and result payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            word_reg   <= mask_word(data_word, valid_bytes);
            len_reg    <= message_length[LEN_W-1:0];
            absorb_reg <= absorb_in;
            last_reg   <= last_word;
        end
        emit_reg     <= emit_next;
        out_hash_reg <= out_hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

endmodule

// ===== src/fh64_checker.sv =====
`include "fasthash64_stream_hasher_top_assert.svh"

module fh64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [63:0] data_word,
    input logic [3:0]  valid_bytes,
    input logic        first_word,
    input logic        last_word,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] hash_value
);

    // A stalled result keeps its value.
    `FH64_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(hash_value))

    // A stalled request keeps its payload.
    `FH64_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(data_word) && $stable(valid_bytes))

    // The block is busy right after it takes a request that has work in it.
    `FH64_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready && (first_word || last_word || valid_bytes != 4'd0), !in_ready)

    // No result can be produced in the cycle right after a request is taken.
    `FH64_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind fasthash64_stream_hasher_top fh64_checker u_fh64_checker (.*);
